### sv/rte_pkg.sv
package rte_pkg;

  // default table depth
  localparam int unsigned TABLE_ENTRIES_DEF = 8;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] dest_addr_hi;
    logic [63:0] dest_addr_lo;
    logic [63:0] target_addr_hi;
    logic [63:0] target_addr_lo;
    logic [31:0] now_seconds;
  } rte_in_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  slot;
    logic [63:0] addr_out_hi;
    logic [63:0] addr_out_lo;
  } rte_out_t;

  // one table entry, all fields held in one memory word
  typedef struct packed {
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic [63:0] tgt_hi;
    logic [63:0] tgt_lo;
    logic [31:0] stamp;
  } rte_entry_t;

endpackage

### sv/rte_mem.sv
module rte_mem #(
  parameter int unsigned DEPTH = rte_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned AW    = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output rte_pkg::rte_entry_t rd_entry,
  input  logic                we,
  input  logic [AW-1:0]       wr_addr,
  input  rte_pkg::rte_entry_t wr_entry
);
  import rte_pkg::*;

  rte_entry_t       mem_r [DEPTH];
  rte_entry_t       rd_data_r;
  logic             rd_valid_r;
  logic [DEPTH-1:0] valid_r;

  // storage array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // per-entry valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_entry = rd_valid_r ? rd_data_r : '0;

endmodule

### sv/redirect_table_engine.sv
// Redirect table engine: fully associative table of TABLE_ENTRIES slots,
// 128-bit destination key -> 128-bit redirect target; an add replaces
// a matching slot, else the first free slot, else the oldest stamp.
// Input channel (in_valid / in_stall / in_data): one item per command,
// cmd selects lookup or add. Output channel (out_valid / out_stall /
// out_data): exactly one result item per input item, in order.
// Each item scans the table memory (one read and one write port) one
// entry per cycle, through an accept cycle, the scan (registered reads)
// and a response/write-back cycle; the result is valid in the cycle
// after the response cycle.
// Only one item is in flight, so a write-back always lands before the
// next scan reads the table.
// Reset (rst_n low, synchronous) clears the control state and the
// per-entry valid bits, so the whole table reads as zero at once.
// A result waits in the output register while out_stall is high; a new
// item is still taken and scanned, and only its response cycle waits
// until the output register is free.
module redirect_table_engine #(
  parameter int unsigned TABLE_ENTRIES = rte_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rte_pkg::rte_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rte_pkg::rte_out_t out_data
);
  import rte_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  state_t      state_r, state_nxt;
  rte_in_t     req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;
  // search accumulators
  logic        match_found_r, match_found_nxt;
  logic [AW-1:0] match_idx_r, match_idx_nxt;
  logic [63:0] match_tgt_hi_r, match_tgt_hi_nxt;
  logic [63:0] match_tgt_lo_r, match_tgt_lo_nxt;
  logic        free_found_r, free_found_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [31:0] min_stamp_r, min_stamp_nxt;
  logic [AW-1:0] min_idx_r, min_idx_nxt;
  // output register
  logic        out_valid_r, out_valid_nxt;
  rte_out_t    out_data_r, out_data_nxt;

  logic        accept;
  logic        out_free;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  rte_entry_t  rd_entry;
  logic        mem_we;
  logic [AW-1:0] wr_addr;
  rte_entry_t  wr_entry;
  logic        dest_eq;
  logic        dest_zero;
  logic [AW-1:0] sel;

  rte_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .we       (mem_we),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // scan issues one read per cycle, addresses 0 .. TABLE_ENTRIES-1
  assign rd_en   = (state_r == S_SCAN) && (cnt_r != CNT_END);
  assign rd_addr = cnt_r[AW-1:0];

  // compare the entry returned for cmp_idx_r against the key
  assign dest_eq   = (rd_entry.dest_hi == req_r.dest_addr_hi) &&
                     (rd_entry.dest_lo == req_r.dest_addr_lo);
  assign dest_zero = (rd_entry.dest_hi == 64'd0) && (rd_entry.dest_lo == 64'd0);

  // replacement choice: match, else first free, else oldest stamp
  always_comb begin
    if (match_found_r) begin
      sel = match_idx_r;
    end else if (free_found_r) begin
      sel = free_idx_r;
    end else begin
      sel = min_idx_r;
    end
  end

  assign mem_we   = (state_r == S_RESP) && out_free && (req_r.cmd == CMD_ADD);
  assign wr_addr  = sel;
  assign wr_entry = '{dest_hi: req_r.dest_addr_hi,
                      dest_lo: req_r.dest_addr_lo,
                      tgt_hi:  req_r.target_addr_hi,
                      tgt_lo:  req_r.target_addr_lo,
                      stamp:   req_r.now_seconds};

  always_comb begin
    state_nxt        = state_r;
    req_nxt          = req_r;
    cnt_nxt          = cnt_r;
    match_found_nxt  = match_found_r;
    match_idx_nxt    = match_idx_r;
    match_tgt_hi_nxt = match_tgt_hi_r;
    match_tgt_lo_nxt = match_tgt_lo_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    min_stamp_nxt    = min_stamp_r;
    min_idx_nxt      = min_idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt         = in_data;
          cnt_nxt         = '0;
          match_found_nxt = 1'b0;
          free_found_nxt  = 1'b0;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (cmp_vld_r) begin
          if (!match_found_r && dest_eq) begin
            match_found_nxt  = 1'b1;
            match_idx_nxt    = cmp_idx_r;
            match_tgt_hi_nxt = rd_entry.tgt_hi;
            match_tgt_lo_nxt = rd_entry.tgt_lo;
          end
          if (!free_found_r && dest_zero) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          // strict less-than keeps the lowest index on ties
          if ((cmp_idx_r == '0) || (rd_entry.stamp < min_stamp_r)) begin
            min_stamp_nxt = rd_entry.stamp;
            min_idx_nxt   = cmp_idx_r;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (req_r.cmd == CMD_ADD) begin
            out_data_nxt = '{hit:         match_found_r,
                             slot:        3'(sel),
                             addr_out_hi: req_r.target_addr_hi,
                             addr_out_lo: req_r.target_addr_lo};
          end else if (match_found_r) begin
            out_data_nxt = '{hit:         1'b1,
                             slot:        3'(match_idx_r),
                             addr_out_hi: match_tgt_hi_r,
                             addr_out_lo: match_tgt_lo_r};
          end else begin
            out_data_nxt = '{hit:         1'b0,
                             slot:        3'd0,
                             addr_out_hi: req_r.dest_addr_hi,
                             addr_out_lo: req_r.dest_addr_lo};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
    req_r          <= req_nxt;
    cnt_r          <= cnt_nxt;
    cmp_idx_r      <= rd_addr;
    match_found_r  <= match_found_nxt;
    match_idx_r    <= match_idx_nxt;
    match_tgt_hi_r <= match_tgt_hi_nxt;
    match_tgt_lo_r <= match_tgt_lo_nxt;
    free_found_r   <= free_found_nxt;
    free_idx_r     <= free_idx_nxt;
    min_stamp_r    <= min_stamp_nxt;
    min_idx_r      <= min_idx_nxt;
    out_data_r     <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // table is written only by an add, and only from the response cycle
  a_we_add_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (req_r.cmd == CMD_ADD) && (state_r == S_RESP))
    else $error("table write outside add response");

  // read data arrives only while scanning
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == S_SCAN))
    else $error("compare data outside scan");

  // a response cycle with a free output register always yields a result
  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("response not delivered");

  // a taken item starts a clean scan: counter at zero, no compare data pending
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN) && (cnt_r == '0) && !cmp_vld_r)
    else $error("scan did not start clean");

endmodule
